>>> hw/rtl/cbe_pkg.sv
`default_nettype none

package cbe_pkg;

  localparam int unsigned MAX_RUN       = 64;
  localparam int unsigned READ_POS_BITS = 16;
  localparam int unsigned REF_POS_BITS  = 24;

  localparam int unsigned RUN_LEN_BITS  = 7;
  localparam int unsigned FRAG_BITS     = 21;
  localparam int unsigned HDR_LEN_BITS  = 16;
  localparam int unsigned REF_OFF_BITS  = 25;
  localparam int unsigned DIST_BITS     = 21;
  localparam int unsigned K_BITS        = 24;
  localparam int unsigned SUM_BITS      = K_BITS + 1;

  localparam logic [RUN_LEN_BITS-1:0] MAX_RUN_LEN = RUN_LEN_BITS'(MAX_RUN);
  localparam logic [REF_POS_BITS-1:0] REF_MAX     = '1;
  localparam logic [READ_POS_BITS-1:0] READ_MAX   = '1;

  localparam logic signed [SUM_BITS-1:0] DIST_MIN_EXT = -(SUM_BITS'(1) <<< (DIST_BITS - 1));
  localparam logic signed [SUM_BITS-1:0] DIST_MAX_EXT = (SUM_BITS'(1) <<< (DIST_BITS - 1)) - 1;

  typedef enum logic [3:0] {
    OP_M  = 4'd0,
    OP_EQ = 4'd1,
    OP_X  = 4'd2,
    OP_S  = 4'd3,
    OP_I  = 4'd4,
    OP_D  = 4'd5,
    OP_N  = 4'd6,
    OP_H  = 4'd7,
    OP_P  = 4'd8
  } cigar_op_e;

  typedef enum logic {
    ITEM_HEADER = 1'b0,
    ITEM_RUN    = 1'b1
  } item_e;

  typedef enum logic [1:0] {
    KIND_ALN,
    KIND_SOFT,
    KIND_INS,
    KIND_BAD
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                    hdr_load;
    logic                    start_run;
    kind_e                   kind;
    logic                    skip_ref;
    logic [RUN_LEN_BITS-1:0] skip_len;
    logic                    emit;
    logic                    emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [DIST_BITS-1:0] sat_dist(logic signed [SUM_BITS-1:0] v);
    logic signed [DIST_BITS-1:0] r;
    if (v < DIST_MIN_EXT) begin
      r = DIST_MIN_EXT[DIST_BITS-1:0];
    end else if (v > DIST_MAX_EXT) begin
      r = DIST_MAX_EXT[DIST_BITS-1:0];
    end else begin
      r = v[DIST_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cbe_if.sv
`default_nettype none

interface cbe_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [3:0]                            cigar_op;
  logic [cbe_pkg::RUN_LEN_BITS-1:0]      run_length;
  logic                                  proper_pair;
  logic                                  reverse_strand;
  logic signed [cbe_pkg::FRAG_BITS-1:0]  fragment_len;
  logic [cbe_pkg::HDR_LEN_BITS-1:0]      sequenced_len;
  logic [cbe_pkg::HDR_LEN_BITS-1:0]      left_clip_len;

  modport source (
    output valid, operation, cigar_op, run_length, proper_pair, reverse_strand,
           fragment_len, sequenced_len, left_clip_len,
    input  ready
  );
  modport sink (
    input  valid, operation, cigar_op, run_length, proper_pair, reverse_strand,
           fragment_len, sequenced_len, left_clip_len,
    output ready
  );
endinterface

interface cbe_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [15:0]                             read_index;
  logic signed [cbe_pkg::REF_OFF_BITS-1:0] ref_offset;
  logic                                    aligned;
  logic                                    soft_clipped;
  logic                                    has_distance;
  logic signed [cbe_pkg::DIST_BITS-1:0]    dist_five;
  logic signed [cbe_pkg::DIST_BITS-1:0]    dist_three;
  logic                                    bad_op;
  logic                                    last;

  modport source (
    output valid, read_index, ref_offset, aligned, soft_clipped, has_distance,
           dist_five, dist_three, bad_op, last,
    input  ready
  );
  modport sink (
    input  valid, read_index, ref_offset, aligned, soft_clipped, has_distance,
           dist_five, dist_three, bad_op, last,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/cigar_base_expander_core.sv
// Expands CIGAR run beats into one record beat per read base. A header beat
// loads strand, pairing and length data and clears the counters; it, and any
// D, N, H or P run, is accepted and leaves the block idle. A base-emitting run
// of n bases (n capped at 64) occupies the block until all are emitted: it is
// accepted, then one record per cycle goes into the output register, which
// refills in the same cycle it is taken. An invalid op gives one error record.
// Downstream stalls stretch the run cycle for cycle; input is not taken while
// a run is still emitting.
`default_nettype none

module cigar_base_expander_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cbe_in_if.sink    in_i,
  cbe_out_if.source out_o
);
  import cbe_pkg::*;

  cmd_t    cmd;
  status_t status;

  cbe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .operation_i  (in_i.operation),
    .cigar_op_i   (in_i.cigar_op),
    .run_length_i (in_i.run_length),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  cbe_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .proper_pair_i    (in_i.proper_pair),
    .reverse_strand_i (in_i.reverse_strand),
    .fragment_len_i   (in_i.fragment_len),
    .sequenced_len_i  (in_i.sequenced_len),
    .left_clip_len_i  (in_i.left_clip_len),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_o            (out_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/cbe_ctrl.sv
`default_nettype none

module cbe_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             operation_i,
  input  wire logic [3:0]                       cigar_op_i,
  input  wire logic [cbe_pkg::RUN_LEN_BITS-1:0] run_length_i,
  input  cbe_pkg::status_t                      status_i,
  output cbe_pkg::cmd_t                         cmd_o
);
  import cbe_pkg::*;

  state_e                  state_q, state_d;
  logic [RUN_LEN_BITS-1:0] count_q, count_d;
  logic [RUN_LEN_BITS-1:0] len_cap;
  logic                    accept;

  assign len_cap = (run_length_i > MAX_RUN_LEN) ? MAX_RUN_LEN : run_length_i;
  assign accept  = in_valid_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (item_e'(operation_i) == ITEM_RUN)) begin
          unique case (cigar_op_e'(cigar_op_i))
            OP_M, OP_EQ, OP_X, OP_S, OP_I: begin
              if (len_cap != '0) begin
                state_d = ST_EMIT;
                count_d = len_cap;
              end
            end
            OP_D, OP_N, OP_H, OP_P: ;
            default: begin
              state_d = ST_EMIT;
              count_d = RUN_LEN_BITS'(1);
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          count_d = count_q - RUN_LEN_BITS'(1);
          if (count_q == RUN_LEN_BITS'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o      = '0;
    cmd_o.kind = KIND_INS;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_e'(operation_i) == ITEM_HEADER) begin
            cmd_o.hdr_load = 1'b1;
          end else begin
            unique case (cigar_op_e'(cigar_op_i))
              OP_M, OP_EQ, OP_X: begin
                cmd_o.start_run = 1'b1;
                cmd_o.kind      = KIND_ALN;
              end
              OP_S: begin
                cmd_o.start_run = 1'b1;
                cmd_o.kind      = KIND_SOFT;
              end
              OP_I: begin
                cmd_o.start_run = 1'b1;
                cmd_o.kind      = KIND_INS;
              end
              OP_D, OP_N: begin
                cmd_o.skip_ref = 1'b1;
                cmd_o.skip_len = len_cap;
              end
              OP_H, OP_P: ;
              default: begin
                cmd_o.start_run = 1'b1;
                cmd_o.kind      = KIND_BAD;
              end
            endcase
          end
        end
      end
      ST_EMIT: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_last = (count_q == RUN_LEN_BITS'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cbe_datapath.sv
`default_nettype none

module cbe_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 proper_pair_i,
  input  wire logic                                 reverse_strand_i,
  input  wire logic signed [cbe_pkg::FRAG_BITS-1:0] fragment_len_i,
  input  wire logic [cbe_pkg::HDR_LEN_BITS-1:0]     sequenced_len_i,
  input  wire logic [cbe_pkg::HDR_LEN_BITS-1:0]     left_clip_len_i,
  input  cbe_pkg::cmd_t                             cmd_i,
  output cbe_pkg::status_t                          status_o,
  cbe_out_if.source                                 out_o
);
  import cbe_pkg::*;

  logic [READ_POS_BITS-1:0]   read_pos_q, read_pos_d;
  logic [REF_POS_BITS-1:0]    ref_pos_q, ref_pos_d;
  logic [HDR_LEN_BITS-1:0]    clip_q;
  logic [HDR_LEN_BITS:0]      end_q;
  logic signed [K_BITS-1:0]   k5_q, k3_q;
  logic                       neg5_q, neg3_q;
  kind_e                      kind_q;

  logic signed [K_BITS-1:0]   c_ext, s_ext, f_ext, k5_d, k3_d;
  logic                       neg3_d;
  logic [REF_POS_BITS:0]      skip_sum;
  logic signed [SUM_BITS-1:0] pos_ext, d5_sum, d3_sum;
  logic                       has, aligned, out_free;

  logic                              valid_q;
  logic [15:0]                       read_index_q;
  logic signed [REF_OFF_BITS-1:0]    ref_offset_q;
  logic                              aligned_q, soft_q, has_q, bad_q, last_q;
  logic signed [DIST_BITS-1:0]       d5_q, d3_q;

  // header constants: each distance is k plus or minus the read position
  assign c_ext = K_BITS'(left_clip_len_i);
  assign s_ext = K_BITS'(sequenced_len_i);
  assign f_ext = K_BITS'(fragment_len_i);

  always_comb begin
    k5_d = reverse_strand_i ? (s_ext - K_BITS'(1) + c_ext) : -c_ext;
    priority if (proper_pair_i && reverse_strand_i) begin
      k3_d   = f_ext - s_ext - c_ext;
      neg3_d = 1'b0;
    end else if (proper_pair_i) begin
      k3_d   = f_ext - K_BITS'(1) + c_ext;
      neg3_d = 1'b1;
    end else if (reverse_strand_i) begin
      k3_d   = -c_ext;
      neg3_d = 1'b0;
    end else begin
      k3_d   = s_ext - K_BITS'(1) + c_ext;
      neg3_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
      end_q  <= '0;
      k5_q   <= '0;
      k3_q   <= '0;
      neg5_q <= 1'b0;
      neg3_q <= 1'b0;
      kind_q <= KIND_INS;
    end else begin
      if (cmd_i.hdr_load) begin
        clip_q <= left_clip_len_i;
        end_q  <= {1'b0, left_clip_len_i} + {1'b0, sequenced_len_i};
        k5_q   <= k5_d;
        k3_q   <= k3_d;
        neg5_q <= reverse_strand_i;
        neg3_q <= neg3_d;
      end
      if (cmd_i.start_run) begin
        kind_q <= cmd_i.kind;
      end
    end
  end

  // counters
  assign aligned  = (kind_q == KIND_ALN);
  assign skip_sum = {1'b0, ref_pos_q} + (REF_POS_BITS + 1)'(cmd_i.skip_len);

  always_comb begin
    read_pos_d = read_pos_q;
    ref_pos_d  = ref_pos_q;
    if (cmd_i.hdr_load) begin
      read_pos_d = '0;
      ref_pos_d  = '0;
    end else if (cmd_i.skip_ref) begin
      ref_pos_d = skip_sum[REF_POS_BITS] ? REF_MAX : skip_sum[REF_POS_BITS-1:0];
    end else if (cmd_i.emit && (kind_q != KIND_BAD)) begin
      if (read_pos_q != READ_MAX) begin
        read_pos_d = read_pos_q + READ_POS_BITS'(1);
      end
      if (aligned && (ref_pos_q != REF_MAX)) begin
        ref_pos_d = ref_pos_q + REF_POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q <= '0;
      ref_pos_q  <= '0;
    end else begin
      read_pos_q <= read_pos_d;
      ref_pos_q  <= ref_pos_d;
    end
  end

  // record
  assign pos_ext = SUM_BITS'(read_pos_q);
  assign d5_sum  = neg5_q ? (SUM_BITS'(k5_q) - pos_ext) : (SUM_BITS'(k5_q) + pos_ext);
  assign d3_sum  = neg3_q ? (SUM_BITS'(k3_q) - pos_ext) : (SUM_BITS'(k3_q) + pos_ext);
  assign has     = (kind_q != KIND_BAD) && (read_pos_q >= clip_q) &&
                   ({1'b0, read_pos_q} < end_q);

  assign out_free          = !valid_q || out_o.ready;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      read_index_q <= read_pos_q;
      ref_offset_q <= aligned ? REF_OFF_BITS'(ref_pos_q) : '1;
      aligned_q    <= aligned;
      soft_q       <= (kind_q == KIND_SOFT);
      has_q        <= has;
      d5_q         <= has ? sat_dist(d5_sum) : '0;
      d3_q         <= has ? sat_dist(d3_sum) : '0;
      bad_q        <= (kind_q == KIND_BAD);
      last_q       <= cmd_i.emit_last;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.read_index   = read_index_q;
  assign out_o.ref_offset   = ref_offset_q;
  assign out_o.aligned      = aligned_q;
  assign out_o.soft_clipped = soft_q;
  assign out_o.has_distance = has_q;
  assign out_o.dist_five    = d5_q;
  assign out_o.dist_three   = d3_q;
  assign out_o.bad_op       = bad_q;
  assign out_o.last         = last_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_cigar_base_expander_core.sv
module tb_cigar_base_expander_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned RANDOM_BEATS = 85;

  localparam logic [3:0] OP_BAD_LO = 4'd9;
  localparam logic [3:0] OP_BAD_HI = 4'd15;
  localparam logic signed [FRAG_BITS-1:0] FRAG_MIN = 21'h100000;
  localparam logic signed [FRAG_BITS-1:0] FRAG_MAX = 21'h0FFFFF;
  localparam logic signed [REF_OFF_BITS-1:0] REF_NONE = '1;

  typedef struct packed {
    item_e                          operation;
    logic [3:0]                     cigar_op;
    logic [RUN_LEN_BITS-1:0]        run_length;
    logic                           proper_pair;
    logic                           reverse_strand;
    logic signed [FRAG_BITS-1:0]    fragment_len;
    logic [HDR_LEN_BITS-1:0]        sequenced_len;
    logic [HDR_LEN_BITS-1:0]        left_clip_len;
  } cigar_beat_t;

  typedef struct packed {
    logic [15:0]                    read_index;
    logic signed [REF_OFF_BITS-1:0] ref_offset;
    logic                           aligned;
    logic                           soft_clipped;
    logic                           has_distance;
    logic signed [DIST_BITS-1:0]    dist_five;
    logic signed [DIST_BITS-1:0]    dist_three;
    logic                           bad_op;
    logic                           last;
  } base_rec_t;

  typedef struct packed {
    cigar_beat_t beat;
    logic        typed;
    base_rec_t   rec;
  } dir_row_t;

  localparam base_rec_t NO_REC = '0;

  logic clk;
  logic rst_n = 1'b0;
  logic steady = 1'b0;

  cbe_in_if  in_bus ();
  cbe_out_if out_bus ();

  cigar_base_expander_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // shadow of the block's read state
  logic [READ_POS_BITS-1:0]    read_ctr;
  logic [REF_POS_BITS-1:0]     ref_ctr;
  logic                        pair_q;
  logic                        rev_q;
  logic signed [FRAG_BITS-1:0] frag_q;
  logic [HDR_LEN_BITS-1:0]     seq_q;
  logic [HDR_LEN_BITS-1:0]     clip_q;

  base_rec_t fresh_recs[$];
  base_rec_t awaited_recs[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned records_checked = 0;

  dir_row_t directed_rows [25] = '{
    '{'{ITEM_RUN, OP_M, 7'd1, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, 25'sd0, 1'b1, 1'b0, 1'b0, 21'sd0, 21'sd0, 1'b0, 1'b1}},
    '{'{ITEM_RUN, OP_BAD_HI, 7'd0, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b1,
      '{16'd1, REF_NONE, 1'b0, 1'b0, 1'b0, 21'sd0, 21'sd0, 1'b1, 1'b1}},
    '{'{ITEM_RUN, OP_BAD_LO, 7'd127, 1'b1, 1'b1, FRAG_MAX, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'd1, REF_NONE, 1'b0, 1'b0, 1'b0, 21'sd0, 21'sd0, 1'b1, 1'b1}},
    '{'{ITEM_RUN, OP_H, 7'd127, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_P, 7'd64, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_HEADER, OP_M, 7'd0, 1'b1, 1'b0, 21'sd300, 16'd10, 16'd2}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_S, 7'd2, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_M, 7'd5, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_I, 7'd1, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_EQ, 7'd2, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_X, 7'd1, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_D, 7'd3, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_N, 7'd64, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_M, 7'd0, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_S, 7'd127, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_HEADER, OP_M, 7'd0, 1'b1, 1'b1, FRAG_MIN, 16'd100, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_M, 7'd3, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_D, 7'd127, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_X, 7'd2, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_HEADER, OP_M, 7'd0, 1'b0, 1'b1, FRAG_MAX, 16'hFFFF, 16'hFFFF}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_I, 7'd64, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_HEADER, OP_M, 7'd0, 1'b0, 1'b0, 21'sd1, 16'd5, 16'd1}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_M, 7'd8, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_BAD_HI, 7'd5, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC},
    '{'{ITEM_RUN, OP_EQ, 7'd3, 1'b0, 1'b0, 21'sd0, 16'd0, 16'd0}, 1'b0, NO_REC}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [DIST_BITS-1:0] clamp_dist(int v);
    if (v < -1048576) return FRAG_MIN;
    if (v > 1048575) return FRAG_MAX;
    return v[DIST_BITS-1:0];
  endfunction

  function automatic base_rec_t base_record(logic alig, logic clipped, logic bad);
    base_rec_t r;
    int p;
    int c;
    int s;
    int f;
    int d5;
    int d3;
    p = read_ctr;
    c = clip_q;
    s = seq_q;
    f = frag_q;
    d5 = 0;
    d3 = 0;
    r = '0;
    r.has_distance = !bad && p >= c && p < c + s;
    if (r.has_distance) begin
      d5 = rev_q ? s - 1 + c - p : p - c;
      if (pair_q) begin
        d3 = rev_q ? p + f - s - c : f - 1 + c - p;
      end else begin
        d3 = rev_q ? p - c : s - 1 + c - p;
      end
    end
    r.read_index = read_ctr;
    r.ref_offset = alig ? $signed({1'b0, ref_ctr}) : REF_NONE;
    r.aligned = alig;
    r.soft_clipped = clipped;
    r.dist_five = clamp_dist(d5);
    r.dist_three = clamp_dist(d3);
    r.bad_op = bad;
    return r;
  endfunction

  // per-base records one beat gives, into fresh_recs
  function automatic void expand_beat(cigar_beat_t b);
    logic [RUN_LEN_BITS-1:0] len;
    logic [REF_POS_BITS:0]   ref_sum;
    logic                    alig;
    base_rec_t               r;
    fresh_recs.delete();
    if (b.operation == ITEM_HEADER) begin
      pair_q = b.proper_pair;
      rev_q = b.reverse_strand;
      frag_q = b.fragment_len;
      seq_q = b.sequenced_len;
      clip_q = b.left_clip_len;
      read_ctr = '0;
      ref_ctr = '0;
      return;
    end
    len = (b.run_length > MAX_RUN_LEN) ? MAX_RUN_LEN : b.run_length;
    case (b.cigar_op)
      OP_M, OP_EQ, OP_X, OP_S, OP_I: begin
        alig = b.cigar_op inside {OP_M, OP_EQ, OP_X};
        for (int i = 0; i < int'(len); i++) begin
          r = base_record(alig, b.cigar_op == OP_S, 1'b0);
          r.last = (i == int'(len) - 1);
          fresh_recs.insert(fresh_recs.size(), r);
          if (read_ctr != '1) read_ctr++;
          if (alig && ref_ctr != '1) ref_ctr++;
        end
      end
      OP_D, OP_N: begin
        ref_sum = {1'b0, ref_ctr} + (REF_POS_BITS + 1)'(len);
        ref_ctr = ref_sum[REF_POS_BITS] ? '1 : ref_sum[REF_POS_BITS-1:0];
      end
      OP_H, OP_P: ;
      default: begin
        r = base_record(1'b0, 1'b0, 1'b1);
        r.last = 1'b1;
        fresh_recs.insert(fresh_recs.size(), r);
      end
    endcase
  endfunction

  function automatic void note_field(string name, logic signed [63:0] want,
                                     logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_bus.ready <= steady || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin : record_check
    base_rec_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready) begin
      if (awaited_recs.size() == 0) begin
        mismatches++;
        $error("unexpected base record, read_index %0d", out_bus.read_index);
      end else begin
        want = awaited_recs.pop_front();
        records_checked++;
        note_field("read_index", want.read_index, out_bus.read_index);
        note_field("ref_offset", want.ref_offset, out_bus.ref_offset);
        note_field("aligned", want.aligned, out_bus.aligned);
        note_field("soft_clipped", want.soft_clipped, out_bus.soft_clipped);
        note_field("has_distance", want.has_distance, out_bus.has_distance);
        note_field("dist_five", want.dist_five, out_bus.dist_five);
        note_field("dist_three", want.dist_three, out_bus.dist_three);
        note_field("bad_op", want.bad_op, out_bus.bad_op);
        note_field("last", want.last, out_bus.last);
      end
    end
  end

  task automatic maybe_idle();
    while (!steady && $urandom_range(99) < 16) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_beat(input cigar_beat_t b, input logic typed, input base_rec_t golden);
    in_bus.valid          <= 1'b1;
    in_bus.operation      <= b.operation;
    in_bus.cigar_op       <= b.cigar_op;
    in_bus.run_length     <= b.run_length;
    in_bus.proper_pair    <= b.proper_pair;
    in_bus.reverse_strand <= b.reverse_strand;
    in_bus.fragment_len   <= b.fragment_len;
    in_bus.sequenced_len  <= b.sequenced_len;
    in_bus.left_clip_len  <= b.left_clip_len;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    expand_beat(b);
    if (typed) begin
      awaited_recs.insert(awaited_recs.size(), golden);
    end else begin
      foreach (fresh_recs[i]) awaited_recs.insert(awaited_recs.size(), fresh_recs[i]);
    end
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (awaited_recs.size() != 0);
  endtask

  function automatic cigar_beat_t random_header();
    cigar_beat_t b;
    b.operation      = ITEM_HEADER;
    b.cigar_op       = 4'($urandom);
    b.run_length     = 7'($urandom);
    b.proper_pair    = 1'($urandom);
    b.reverse_strand = 1'($urandom);
    b.fragment_len   = 21'($urandom);
    if ($urandom_range(1)) begin
      b.sequenced_len = 16'($urandom_range(200));
      b.left_clip_len = 16'($urandom_range(20));
      if ($urandom_range(1)) b.fragment_len = 21'($urandom_range(600));
    end else begin
      b.sequenced_len = 16'($urandom);
      b.left_clip_len = 16'($urandom);
    end
    return b;
  endfunction

  function automatic cigar_beat_t random_run();
    cigar_beat_t b;
    int pick;
    b = random_header();
    b.operation = ITEM_RUN;
    pick = $urandom_range(99);
    if (pick < 60)      b.cigar_op = 4'($urandom_range(OP_M, OP_X));
    else if (pick < 72) b.cigar_op = OP_S;
    else if (pick < 82) b.cigar_op = OP_I;
    else if (pick < 90) b.cigar_op = 4'($urandom_range(OP_D, OP_N));
    else if (pick < 95) b.cigar_op = 4'($urandom_range(OP_H, OP_P));
    else                b.cigar_op = 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    b.run_length = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(12));
    return b;
  endfunction

  // a header and its runs; now and then the header is dropped
  task automatic random_read(input logic headless);
    int runs;
    runs = $urandom_range(1, 6);
    if (!headless) begin
      maybe_idle();
      send_beat(random_header(), 1'b0, NO_REC);
    end
    repeat (runs) begin
      maybe_idle();
      send_beat(random_run(), 1'b0, NO_REC);
    end
  endtask

  initial begin
    int unsigned random_start;
    int reads;
    in_bus.valid          <= 1'b0;
    in_bus.operation      <= ITEM_HEADER;
    in_bus.cigar_op       <= '0;
    in_bus.run_length     <= '0;
    in_bus.proper_pair    <= 1'b0;
    in_bus.reverse_strand <= 1'b0;
    in_bus.fragment_len   <= '0;
    in_bus.sequenced_len  <= '0;
    in_bus.left_clip_len  <= '0;
    read_ctr = '0;
    ref_ctr = '0;
    pair_q = 1'b0;
    rev_q = 1'b0;
    frag_q = '0;
    seq_q = '0;
    clip_q = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      maybe_idle();
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].rec);
    end
    wait_drained();

    random_start = beats_sent;
    reads = 0;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      steady = (reads >= 6 && reads < 12);
      random_read($urandom_range(9) == 0);
      reads++;
      if (reads == 15) wait_drained();
    end
    steady = 1'b0;
    wait_drained();
    repeat (80) @(posedge clk);

    $display("summary: %0d beats, %0d base records checked, %0d mismatches",
             beats_sent, records_checked, mismatches);
    $display("summary: all ops, invalid ops, capped runs, clipped runs, distance saturation");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cbe_pkg.sv
hw/rtl/cbe_if.sv
hw/rtl/cbe_ctrl.sv
hw/rtl/cbe_datapath.sv
hw/rtl/cigar_base_expander_core.sv
tb/sv/tb_cigar_base_expander_core.sv
